[rtl/core/weekly_event_schedule_table_assert.svh]
// Assertion macros for the weekly event schedule table
`ifndef WEEKLY_EVENT_SCHEDULE_TABLE_ASSERT_SVH
`define WEEKLY_EVENT_SCHEDULE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define WEST_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("weekly_event_schedule_table: assertion failed");

// next-cycle implication
`define WEST_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("weekly_event_schedule_table: assertion failed");

`endif

[rtl/core/wevsch_pkg.sv]
// Types, codes and helpers shared by the weekly event schedule table
package wevsch_pkg;

	localparam logic [2:0] KIND_SCHED_ON  = 3'd0;
	localparam logic [2:0] KIND_SCHED_OFF = 3'd1;
	localparam logic [2:0] KIND_RANDOMIZE = 3'd2;
	localparam logic [2:0] KIND_REMOVE    = 3'd3;
	localparam logic [2:0] KIND_WAKE      = 3'd4;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_OOB  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam logic RK_STATUS  = 1'b0;
	localparam logic RK_COMMAND = 1'b1;

	localparam logic [3:0] DAY_SUNDAY   = 4'd0;
	localparam logic [3:0] DAY_MONDAY   = 4'd1;
	localparam logic [3:0] DAY_FRIDAY   = 4'd5;
	localparam logic [3:0] DAY_SATURDAY = 4'd6;
	localparam logic [3:0] DAY_EVERY    = 4'd7;
	localparam logic [3:0] DAY_WEEKDAYS = 4'd8;
	localparam logic [3:0] DAY_WEEKEND  = 4'd9;

	typedef struct packed {
		logic [2:0]        kind;
		logic [7:0]        light_id;
		logic [3:0]        day_code;
		logic [10:0]       minute_of_day;
		logic signed [7:0] random_offset;
	} item_t;

	typedef struct packed {
		logic       result_kind;
		logic [1:0] status;
		logic [7:0] target_light;
		logic       switch_on;
		logic       last;
	} result_t;

	typedef struct packed {
		logic              used;
		logic [7:0]        light;
		logic [3:0]        day;
		logic [10:0]       minute;
		logic              turns_on;
		logic              randomized;
		logic signed [7:0] offset;
	} slot_t;

	typedef struct packed {
		logic fill;
		logic fire;
	} head_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	function automatic logic day_matches(input logic [3:0] slot_day, input logic [3:0] today);
		logic m;
		m = (slot_day == DAY_EVERY) || (slot_day == today);
		if (slot_day == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY))
			m = 1'b1;
		if (slot_day == DAY_WEEKDAYS && today >= DAY_MONDAY && today <= DAY_FRIDAY)
			m = 1'b1;
		return m;
	endfunction

endpackage

[rtl/core/wevsch_cell.sv]
// One slot cell of the rotating event ring
module wevsch_cell
	import wevsch_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);

	logic  used_q;
	slot_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift) begin
			used_q <= d.used;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q      = data_q;
		q.used = used_q;
	end

endmodule

[rtl/core/wevsch_head.sv]
// Head unit: evaluates and rewrites the slot passing the ring head
module wevsch_head
	import wevsch_pkg::*;
(
	input  slot_t       entry,
	input  item_t       item,
	input  logic        oob,
	input  logic        fill_done,
	output slot_t       wb,
	output head_flags_t flags
);

	logic              match;
	logic signed [12:0] due;
	logic signed [12:0] now;

	always_comb begin
		match = entry.used && entry.light == item.light_id && entry.day == item.day_code &&
			entry.minute == item.minute_of_day;
		due   = $signed({2'b00, entry.minute}) +
			$signed({{5{entry.offset[7]}}, entry.offset});
		now   = $signed({2'b00, item.minute_of_day});
		wb    = entry;
		flags = '0;
		case (item.kind)
			KIND_SCHED_ON, KIND_SCHED_OFF: begin
				if (!oob && !fill_done && !entry.used) begin
					flags.fill      = 1'b1;
					wb.used         = 1'b1;
					wb.light        = item.light_id;
					wb.day          = item.day_code;
					wb.minute       = item.minute_of_day;
					wb.turns_on     = (item.kind == KIND_SCHED_ON);
					wb.randomized   = 1'b0;
					wb.offset       = '0;
				end
			end
			KIND_RANDOMIZE: begin
				if (match) begin
					wb.randomized = 1'b1;
					wb.offset     = item.random_offset;
				end
			end
			KIND_REMOVE: begin
				if (match)
					wb.used = 1'b0;
			end
			KIND_WAKE: begin
				if (entry.used && day_matches(entry.day, item.day_code) && due == now) begin
					flags.fire = 1'b1;
					wb.offset  = entry.randomized ? item.random_offset : 8'sd0;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/weekly_event_schedule_table.sv]
// Top level: weekly event schedule table built as a rotating ring of slot cells
//
//   channel   dir  handshake            payload
//   item      in   start & !busy        item_t
//   result    out  strobe (one cycle)   result_t
//
// busy is high from the accepting edge while the ring rotates one slot per cycle past the head
//   unit (ST_SCAN), then through the closing state (ST_DONE); no new item is accepted while busy.
// The status or last command strobes in the cycle after the closing state; a command found
//   during the rotation strobes in the cycle after the next firing slot.
// Reset clears the used bit of each slot but not its data; the table is usable right after reset.
// Results cannot be stalled; strobe marks each for exactly one cycle.
`include "weekly_event_schedule_table_assert.svh"

module weekly_event_schedule_table
	import wevsch_pkg::*;
#(
	parameter int EVENT_SLOTS = 32,
	parameter int LIGHTS      = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	localparam int CW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam logic [CW-1:0] LAST_SLOT = CW'(EVENT_SLOTS - 1);

	state_t      state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic        scan_en;
	logic        accept;
	item_t       item_q;
	logic        oob_q;
	logic        fill_done_q;
	logic        pend_valid_q;
	logic [7:0]  pend_light_q;
	logic        pend_on_q;
	logic        strobe_q;
	result_t     result_q;
	slot_t       ring [EVENT_SLOTS];
	slot_t       wb;
	head_flags_t flags;
	logic        is_sched;

	assign accept   = start && !busy;
	assign is_sched = (item_q.kind == KIND_SCHED_ON) || (item_q.kind == KIND_SCHED_OFF);

	for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
		if (i == EVENT_SLOTS - 1) begin : g_tail
			wevsch_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (scan_en),
				.d     (wb),
				.q     (ring[i])
			);
		end else begin : g_body
			wevsch_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (scan_en),
				.d     (ring[i+1]),
				.q     (ring[i])
			);
		end
	end

	wevsch_head u_head (
		.entry    (ring[0]),
		.item     (item_q),
		.oob      (oob_q),
		.fill_done(fill_done_q),
		.wb       (wb),
		.flags    (flags)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (cnt_q == LAST_SLOT) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != ST_IDLE);
		scan_en = (state_q == ST_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			fill_done_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (accept) begin
				cnt_q        <= '0;
				fill_done_q  <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (scan_en) begin
				cnt_q <= cnt_q + 1'b1;
				if (flags.fill)
					fill_done_q <= 1'b1;
				if (flags.fire) begin
					pend_valid_q <= 1'b1;
					if (pend_valid_q)
						strobe_q <= 1'b1;
				end
			end
			if (state_q == ST_DONE) begin
				pend_valid_q <= 1'b0;
				if (is_sched || (item_q.kind == KIND_WAKE && pend_valid_q))
					strobe_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			oob_q  <= ({1'b0, item.light_id} >= 9'(LIGHTS));
		end
		if (scan_en && flags.fire) begin
			pend_light_q <= ring[0].light;
			pend_on_q    <= ring[0].turns_on;
			if (pend_valid_q)
				result_q <= '{result_kind: RK_COMMAND, status: STATUS_OK,
					target_light: pend_light_q, switch_on: pend_on_q, last: 1'b0};
		end
		if (state_q == ST_DONE) begin
			if (is_sched)
				result_q <= '{result_kind: RK_STATUS,
					status: oob_q ? STATUS_OOB : (fill_done_q ? STATUS_OK : STATUS_FULL),
					target_light: 8'd0, switch_on: 1'b0, last: 1'b0};
			else
				result_q <= '{result_kind: RK_COMMAND, status: STATUS_OK,
					target_light: pend_light_q, switch_on: pend_on_q, last: 1'b1};
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`WEST_ASSERT_NXT(a_accept_busy, accept, busy)
	`WEST_ASSERT_IMP(a_status_closing, strobe && result.result_kind == RK_STATUS,
		$past(state_q) == ST_DONE)
	`WEST_ASSERT_IMP(a_last_closing, strobe && result.last, $past(state_q) == ST_DONE)
	`WEST_ASSERT_NXT(a_scan_end, scan_en && cnt_q == LAST_SLOT, state_q == ST_DONE)
	`WEST_ASSERT_IMP(a_no_fill_twice, scan_en && fill_done_q, !flags.fill)

endmodule
